// ===== rtl/ring_shuttle_sstf_dispatcher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Ring shuttle dispatcher assertion macros
// Shared forms for the concurrent checks of the dispatcher.
// ----------------------------------------------------------------------------
`ifndef RING_SHUTTLE_SSTF_DISPATCHER_UNIT_MACROS_SVH
`define RING_SHUTTLE_SSTF_DISPATCHER_UNIT_MACROS_SVH

// check outside reset
`define RSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define RSSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring shuttle dispatcher package
// Types and constants of the shortest-distance-first ring dispatcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rssd_pkg;

  localparam int MAX_STATIONS = 16;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_TARGET = 2'd1;
  localparam logic [1:0] REQ_CW     = 2'd2;
  localparam logic [1:0] REQ_CCW    = 2'd3;

  localparam logic signed [1:0] HEAD_IDLE = 2'sb00;
  localparam logic signed [1:0] HEAD_CW   = 2'sb01;
  localparam logic signed [1:0] HEAD_CCW  = 2'sb11;

  localparam logic REG_COUNT   = 1'b0;
  localparam logic REG_SPACING = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] stop;
    logic [1:0] age;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_PICK,
    S_FIND,
    S_DROP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ring_shuttle_sstf_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// Ring shuttle dispatcher
// Shortest-distance-first dispatch of a shuttle round a ring of stations.
// ----------------------------------------------------------------------------
// A request (target or call) gives its done strobe in the cycle after the transfer.
// A tick runs up to four sweeps over the request memory, one entry per cycle:
// ageing and station clearing, the nearest-entry search, locating the chosen
// entry and compacting it out. Only when the shuttle is idle and picks a new
// task does a tick run all four; otherwise it runs the first sweep only. The
// request memory has a single read and a single write port. Results are
// shown for one cycle on done and cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

`include "ring_shuttle_sstf_dispatcher_unit_macros.svh"

module ring_shuttle_sstf_dispatcher_unit #(
  parameter int MAX_REQUESTS = 48
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire  [1:0]        req_type,
  input  wire  [4:0]        station,
  output logic              done,
  output logic [6:0]        position,
  output logic signed [1:0] heading,
  output logic              stopped_here,
  output logic              task_active,
  output logic [3:0]        task_station,
  output logic [15:0]       target_flags,
  output logic [15:0]       clockwise_flags,
  output logic [15:0]       counter_flags,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_index,
  input  wire  [4:0]        cfg_data
);

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int AW = $clog2(MAX_REQUESTS);
  localparam int EW = $bits(rssd_pkg::entry_t);

  rssd_pkg::state_t state, state_next;

  logic [EW-1:0] mem [MAX_REQUESTS];
  logic [EW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  logic [4:0]  station_count, station_count_next;
  logic [2:0]  station_spacing, station_spacing_next;
  logic [CW-1:0] count, count_next, idx, idx_next, wr_ptr, wr_ptr_next;
  logic          rd_vld, rd_vld_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next, rm_ptr, rm_ptr_next;
  logic [6:0]  pos, pos_next;
  logic [3:0]  here, here_next;
  logic [2:0]  sub, sub_next;
  logic signed [1:0] head, head_next;
  logic [1:0]  task_kind, task_kind_next;
  logic [3:0]  task_stop, task_stop_next;
  logic [15:0] tgt_flags, tgt_flags_next, cw_flags, cw_flags_next;
  logic [15:0] ccw_flags, ccw_flags_next;
  logic        stopped, stopped_next, removed_any, removed_any_next;
  logic [7:0]  best, best_next;
  logic [1:0]  best_kind, best_kind_next;
  logic [3:0]  best_stop, best_stop_next;
  logic signed [1:0] best_dir, best_dir_next;

  logic [4:0]  eff_cnt;
  logic [2:0]  eff_sp;
  logic [6:0]  ring;
  logic [6:0]  mv_pos;
  logic [3:0]  mv_here;
  logic [2:0]  mv_sub;
  logic        issue, at_stn, arrive, rq_ok, flag_set, aged_rm, match;
  logic [3:0]  rq_s;
  logic [1:0]  aged;
  logic [6:0]  tp, cwd, ccd;
  logic [7:0]  cwd_raw;
  rssd_pkg::entry_t rd_e, wr_e;

  always_comb begin
    eff_cnt = (station_count < 5'd2) ? 5'd2 :
              (station_count > 5'(rssd_pkg::MAX_STATIONS)) ?
              5'(rssd_pkg::MAX_STATIONS) : station_count;
    eff_sp  = (station_spacing == 3'd0) ? 3'd1 : station_spacing;
    ring    = 7'({3'b000, eff_cnt} * {5'b00000, eff_sp});
  end

  // one step along the ring in the current heading
  always_comb begin
    mv_pos  = pos;
    mv_here = here;
    mv_sub  = sub;
    if (head == rssd_pkg::HEAD_CW) begin
      if (pos == 7'(ring - 7'd1)) begin
        mv_pos = '0; mv_here = '0; mv_sub = '0;
      end else begin
        mv_pos = 7'(pos + 7'd1);
        if (sub == 3'(eff_sp - 3'd1)) begin
          mv_sub = '0; mv_here = 4'(here + 4'd1);
        end else begin
          mv_sub = 3'(sub + 3'd1);
        end
      end
    end else if (head == rssd_pkg::HEAD_CCW) begin
      if (pos == 7'd0) begin
        mv_pos = 7'(ring - 7'd1); mv_here = 4'(eff_cnt - 5'd1);
        mv_sub = 3'(eff_sp - 3'd1);
      end else begin
        mv_pos = 7'(pos - 7'd1);
        if (sub == 3'd0) begin
          mv_sub = 3'(eff_sp - 3'd1); mv_here = 4'(here - 4'd1);
        end else begin
          mv_sub = 3'(sub - 3'd1);
        end
      end
    end
  end

  always_comb begin
    rd_e     = rssd_pkg::entry_t'(mem_rdata);
    at_stn   = (sub == 3'd0) && (task_kind != 2'd0);
    arrive   = at_stn && (here == task_stop);
    aged     = (rd_e.age == 2'd2) ? 2'd2 : 2'(rd_e.age + 2'd1);
    match    = (rd_e.kind == rssd_pkg::REQ_TARGET) ||
               ((head == rssd_pkg::HEAD_CW) && (rd_e.kind == rssd_pkg::REQ_CW)) ||
               ((head != rssd_pkg::HEAD_CW) && (rd_e.kind == rssd_pkg::REQ_CCW));
    aged_rm  = arrive ? (rd_e.stop == task_stop) :
               (at_stn && match && (rd_e.stop == here) && (aged == 2'd2));
    tp       = 7'({3'b000, rd_e.stop} * {4'b0000, eff_sp});
    cwd_raw  = {1'b0, tp} - {1'b0, pos};
    cwd      = cwd_raw[7] ? 7'(cwd_raw + {1'b0, ring}) : cwd_raw[6:0];
    ccd      = 7'(ring - cwd);
    rq_s     = 4'(station - 5'd1);
    rq_ok    = (station != 5'd0) && (station <= eff_cnt);
    flag_set = (req_type == rssd_pkg::REQ_TARGET) ? tgt_flags[rq_s] :
               (req_type == rssd_pkg::REQ_CW) ? cw_flags[rq_s] : ccw_flags[rq_s];
  end

  always_comb begin
    state_next           = state;
    station_count_next   = station_count;
    station_spacing_next = station_spacing;
    count_next     = count;
    idx_next       = idx;
    wr_ptr_next    = wr_ptr;
    rd_vld_next    = 1'b0;
    rd_ptr_next    = rd_ptr;
    rm_ptr_next    = rm_ptr;
    pos_next       = pos;
    here_next      = here;
    sub_next       = sub;
    head_next      = head;
    task_kind_next = task_kind;
    task_stop_next = task_stop;
    tgt_flags_next = tgt_flags;
    cw_flags_next  = cw_flags;
    ccw_flags_next = ccw_flags;
    stopped_next   = stopped;
    removed_any_next = removed_any;
    best_next      = best;
    best_kind_next = best_kind;
    best_stop_next = best_stop;
    best_dir_next  = best_dir;
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx[AW-1:0];
    issue     = 1'b0;
    wr_e      = rd_e;
    done      = 1'b0;
    cfg_ready = (state == rssd_pkg::S_IDLE) && !start;

    unique case (state)
      rssd_pkg::S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          if (cfg_index == rssd_pkg::REG_COUNT) station_count_next = cfg_data;
          else station_spacing_next = cfg_data[2:0];
          count_next = '0; pos_next = '0; here_next = '0; sub_next = '0;
          head_next = rssd_pkg::HEAD_IDLE; task_kind_next = '0; task_stop_next = '0;
          tgt_flags_next = '0; cw_flags_next = '0; ccw_flags_next = '0;
        end
        if (start) begin
          stopped_next = 1'b0;
          idx_next = '0; wr_ptr_next = '0; removed_any_next = 1'b0;
          if (req_type == rssd_pkg::REQ_TICK) begin
            state_next = rssd_pkg::S_AGE;
          end else begin
            state_next = rssd_pkg::S_DONE;
            if (rq_ok && !flag_set && (count < CW'(MAX_REQUESTS))) begin
              unique case (req_type)
                rssd_pkg::REQ_TARGET: tgt_flags_next[rq_s] = 1'b1;
                rssd_pkg::REQ_CW:     cw_flags_next[rq_s] = 1'b1;
                default:              ccw_flags_next[rq_s] = 1'b1;
              endcase
              wr_e.kind = req_type; wr_e.stop = rq_s; wr_e.age = 2'd0;
              mem_we = 1'b1; mem_waddr = count[AW-1:0]; mem_wdata = wr_e;
              count_next = CW'(count + CW'(1));
            end
          end
        end
      end

      rssd_pkg::S_AGE: begin
        issue = (idx != count);
        if (issue) idx_next = CW'(idx + CW'(1));
        rd_vld_next = issue;
        if (rd_vld) begin
          if (aged_rm) begin
            removed_any_next = 1'b1;
          end else begin
            wr_e.age = aged;
            mem_we = 1'b1; mem_wdata = wr_e;
            wr_ptr_next = CW'(wr_ptr + CW'(1));
          end
        end
        if (!issue && !rd_vld) begin
          count_next = wr_ptr;
          idx_next = '0; wr_ptr_next = '0;
          state_next = rssd_pkg::S_DONE;
          if (arrive) begin
            tgt_flags_next[task_stop] = 1'b0;
            cw_flags_next[task_stop]  = 1'b0;
            ccw_flags_next[task_stop] = 1'b0;
            task_kind_next = '0; head_next = rssd_pkg::HEAD_IDLE;
            stopped_next = 1'b1;
          end else if (at_stn && removed_any) begin
            tgt_flags_next[here] = 1'b0;
            if (head == rssd_pkg::HEAD_CW) cw_flags_next[here] = 1'b0;
            else ccw_flags_next[here] = 1'b0;
            stopped_next = 1'b1;
          end else if (task_kind == 2'd0) begin
            if (wr_ptr == '0) begin
              head_next = rssd_pkg::HEAD_IDLE;
            end else begin
              best_next = 8'({1'b0, ring} + 8'd1);
              state_next = rssd_pkg::S_PICK;
            end
          end else begin
            pos_next = mv_pos; here_next = mv_here; sub_next = mv_sub;
          end
        end
      end

      rssd_pkg::S_PICK: begin
        // newest first: walk the memory downwards
        issue = (idx != count);
        mem_raddr = AW'(CW'(count - CW'(1) - idx));
        if (issue) idx_next = CW'(idx + CW'(1));
        rd_vld_next = issue;
        if (rd_vld) begin
          if (cwd <= ccd) begin
            if ({1'b0, cwd} <= best) begin
              best_next = {1'b0, cwd}; best_dir_next = rssd_pkg::HEAD_CW;
              best_kind_next = rd_e.kind; best_stop_next = rd_e.stop;
            end
          end else if ({1'b0, ccd} < best) begin
            best_next = {1'b0, ccd}; best_dir_next = rssd_pkg::HEAD_CCW;
            best_kind_next = rd_e.kind; best_stop_next = rd_e.stop;
          end
        end
        if (!issue && !rd_vld) begin
          task_kind_next = best_kind; task_stop_next = best_stop;
          head_next = best_dir;
          idx_next = '0;
          state_next = rssd_pkg::S_FIND;
        end
      end

      rssd_pkg::S_FIND: begin
        issue = (idx != count);
        if (issue) begin
          idx_next = CW'(idx + CW'(1));
          rd_ptr_next = idx[AW-1:0];
        end
        rd_vld_next = issue;
        if (rd_vld && (rd_e.kind == task_kind) && (rd_e.stop == task_stop))
          rm_ptr_next = rd_ptr;
        if (!issue && !rd_vld) begin
          idx_next = '0; wr_ptr_next = '0;
          state_next = rssd_pkg::S_DROP;
        end
      end

      rssd_pkg::S_DROP: begin
        issue = (idx != count);
        if (issue) begin
          idx_next = CW'(idx + CW'(1));
          rd_ptr_next = idx[AW-1:0];
        end
        rd_vld_next = issue;
        if (rd_vld && (rd_ptr != rm_ptr)) begin
          mem_we = 1'b1;
          wr_ptr_next = CW'(wr_ptr + CW'(1));
        end
        if (!issue && !rd_vld) begin
          count_next = wr_ptr;
          idx_next = '0; wr_ptr_next = '0;
          pos_next = mv_pos; here_next = mv_here; sub_next = mv_sub;
          state_next = rssd_pkg::S_DONE;
        end
      end

      rssd_pkg::S_DONE: begin
        done = 1'b1;
        state_next = rssd_pkg::S_IDLE;
      end

      default: state_next = rssd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rssd_pkg::S_IDLE;
      station_count <= 5'd10;
      station_spacing <= 3'd2;
      count <= '0; idx <= '0; wr_ptr <= '0; rd_vld <= 1'b0;
      pos <= '0; here <= '0; sub <= '0;
      head <= rssd_pkg::HEAD_IDLE;
      task_kind <= '0; task_stop <= '0;
      tgt_flags <= '0; cw_flags <= '0; ccw_flags <= '0;
      stopped <= 1'b0; removed_any <= 1'b0;
    end else begin
      state <= state_next;
      station_count <= station_count_next;
      station_spacing <= station_spacing_next;
      count <= count_next; idx <= idx_next; wr_ptr <= wr_ptr_next;
      rd_vld <= rd_vld_next;
      pos <= pos_next; here <= here_next; sub <= sub_next;
      head <= head_next;
      task_kind <= task_kind_next; task_stop <= task_stop_next;
      tgt_flags <= tgt_flags_next; cw_flags <= cw_flags_next;
      ccw_flags <= ccw_flags_next;
      stopped <= stopped_next; removed_any <= removed_any_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    rm_ptr <= rm_ptr_next;
    best <= best_next;
    best_kind <= best_kind_next;
    best_stop <= best_stop_next;
    best_dir <= best_dir_next;
  end

  assign busy            = (state != rssd_pkg::S_IDLE);
  assign position        = pos;
  assign heading         = head;
  assign stopped_here    = stopped;
  assign task_active     = (task_kind != 2'd0);
  assign task_station    = task_stop;
  assign target_flags    = tgt_flags;
  assign clockwise_flags = cw_flags;
  assign counter_flags   = ccw_flags;

  `RSSD_ASSERT(a_count_bound, count <= CW'(MAX_REQUESTS), "request count overflow")
  `RSSD_ASSERT(a_done_idle, done |=> !busy, "busy after result transfer")
  `RSSD_ASSERT(a_task_heading, (task_kind != 2'd0) |-> (head != rssd_pkg::HEAD_IDLE), "task without heading")
  `RSSD_ASSERT(a_compact, wr_ptr <= idx, "compaction write overtook read")
  `RSSD_ASSERT_RST(a_reset, rst |=> (state == rssd_pkg::S_IDLE) && (count == '0), "reset state wrong")

endmodule

`default_nettype wire

// ===== tb/sv/ring_shuttle_sstf_dispatcher_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Ring shuttle dispatcher testbench
// Drives ticks and requests through the command port and compares every
// done strobe with a behavioural predictor of the dispatcher held in the
// bench, across several ring sizes and spacings and varying idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ring_shuttle_sstf_dispatcher_unit_tb;

  localparam int STORE_DEPTH = 48;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [6:0]        position;
    logic signed [1:0] heading;
    logic              stopped_here;
    logic              task_active;
    logic [3:0]        task_station;
    logic [15:0]       target_flags;
    logic [15:0]       clockwise_flags;
    logic [15:0]       counter_flags;
  } status_t;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] stop;
    logic [1:0] age;
  } call_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] req_type = rssd_pkg::REQ_TICK;
  logic [4:0] station = '0;
  logic cfg_valid = 1'b0;
  logic cfg_index = rssd_pkg::REG_COUNT;
  logic [4:0] cfg_data = '0;
  logic busy, done, stopped_here, task_active, cfg_ready;
  logic [6:0] position;
  logic signed [1:0] heading;
  logic [3:0] task_station;
  logic [15:0] target_flags, clockwise_flags, counter_flags;

  ring_shuttle_sstf_dispatcher_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .station(station), .done(done),
    .position(position), .heading(heading), .stopped_here(stopped_here),
    .task_active(task_active), .task_station(task_station),
    .target_flags(target_flags), .clockwise_flags(clockwise_flags),
    .counter_flags(counter_flags), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [4:0] m_count;
  logic [2:0] m_spacing;
  call_t calls[$];
  int shuttle_pos, shuttle_dir;
  logic [1:0] job_kind;
  logic [3:0] job_stop;
  logic [15:0] tgt_pend, cw_pend, ccw_pend;

  status_t expected_status[$];
  int errors = 0;
  int gap_pct = 0;
  longint cycle_count = 0;

  function automatic int ring_stations();
    if (m_count < 2) return 2;
    if (m_count > rssd_pkg::MAX_STATIONS) return rssd_pkg::MAX_STATIONS;
    return int'(m_count);
  endfunction

  function automatic int unit_spacing();
    return (m_spacing == 0) ? 1 : int'(m_spacing);
  endfunction

  function automatic void clear_dispatch();
    calls.delete();
    shuttle_pos = 0;
    shuttle_dir = 0;
    job_kind = rssd_pkg::REQ_TICK;
    job_stop = '0;
    tgt_pend = '0;
    cw_pend = '0;
    ccw_pend = '0;
  endfunction

  function automatic void choose_nearest(int ring);
    int best, cwd, ccd;
    best = ring + 1;
    if (calls.size() == 0) begin
      shuttle_dir = 0;
      job_kind = rssd_pkg::REQ_TICK;
      return;
    end
    foreach (calls[i]) begin
      cwd = int'(calls[i].stop) * unit_spacing() - shuttle_pos;
      if (cwd < 0) cwd += ring;
      ccd = ring - cwd;
      if (cwd <= ccd) begin
        if (cwd <= best) begin
          best = cwd;
          shuttle_dir = 1;
          job_kind = calls[i].kind;
          job_stop = calls[i].stop;
        end
      end else if (ccd < best) begin
        best = ccd;
        shuttle_dir = -1;
        job_kind = calls[i].kind;
        job_stop = calls[i].stop;
      end
    end
    foreach (calls[i]) begin
      if (calls[i].kind == job_kind && calls[i].stop == job_stop) begin
        calls.delete(i);
        break;
      end
    end
  endfunction

  function automatic bit serve_station();
    int here, i;
    bit stop_now, cw, hit;
    here = shuttle_pos / unit_spacing();
    i = 0;
    stop_now = 0;
    if (job_kind == rssd_pkg::REQ_TICK) return 0;
    if (here != job_stop) begin
      cw = (shuttle_dir == 1);
      while (i < calls.size()) begin
        hit = (cw && calls[i].kind == rssd_pkg::REQ_CW) ||
              (!cw && calls[i].kind == rssd_pkg::REQ_CCW) ||
              calls[i].kind == rssd_pkg::REQ_TARGET;
        if (hit && calls[i].stop == here && calls[i].age >= 2) begin
          stop_now = 1;
          calls.delete(i);
        end else begin
          i++;
        end
      end
      if (stop_now) begin
        if (cw) cw_pend[here] = 1'b0;
        else ccw_pend[here] = 1'b0;
        tgt_pend[here] = 1'b0;
      end
    end else begin
      stop_now = 1;
      while (i < calls.size()) begin
        if (calls[i].stop == job_stop) calls.delete(i);
        else i++;
      end
      tgt_pend[job_stop] = 1'b0;
      cw_pend[job_stop] = 1'b0;
      ccw_pend[job_stop] = 1'b0;
      job_kind = rssd_pkg::REQ_TICK;
      shuttle_dir = 0;
    end
    return stop_now;
  endfunction

  function automatic bit advance_tick();
    int ring;
    ring = ring_stations() * unit_spacing();
    foreach (calls[i]) if (calls[i].age < 2) calls[i].age++;
    if (shuttle_pos % unit_spacing() == 0)
      if (serve_station()) return 1;
    if (job_kind == rssd_pkg::REQ_TICK) choose_nearest(ring);
    if (job_kind == rssd_pkg::REQ_TICK) return 0;
    shuttle_pos += shuttle_dir;
    if (shuttle_pos < 0) shuttle_pos = ring - 1;
    if (shuttle_pos >= ring) shuttle_pos = 0;
    return 0;
  endfunction

  function automatic void log_call(logic [1:0] kind, logic [4:0] stn);
    call_t c;
    int s;
    bit pend;
    if (stn < 1 || stn > ring_stations()) return;
    s = int'(stn) - 1;
    pend = (kind == rssd_pkg::REQ_TARGET) ? tgt_pend[s] :
           (kind == rssd_pkg::REQ_CW) ? cw_pend[s] : ccw_pend[s];
    if (pend) return;
    if (calls.size() >= STORE_DEPTH) return;
    if (kind == rssd_pkg::REQ_TARGET) tgt_pend[s] = 1'b1;
    else if (kind == rssd_pkg::REQ_CW) cw_pend[s] = 1'b1;
    else ccw_pend[s] = 1'b1;
    c.kind = kind;
    c.stop = s[3:0];
    c.age = 2'd0;
    calls.push_front(c);
  endfunction

  function automatic status_t predict_status(logic [1:0] kind, logic [4:0] stn);
    status_t r;
    bit stopped;
    stopped = 0;
    if (kind == rssd_pkg::REQ_TICK) stopped = advance_tick();
    else log_call(kind, stn);
    r.position = shuttle_pos[6:0];
    r.heading = shuttle_dir[1:0];
    r.stopped_here = stopped;
    r.task_active = (job_kind != rssd_pkg::REQ_TICK);
    r.task_station = job_stop;
    r.target_flags = tgt_pend;
    r.clockwise_flags = cw_pend;
    r.counter_flags = ccw_pend;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    status_t got, want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ring_shuttle_sstf_dispatcher_unit regression: fail");
      $finish;
    end
    if (!rst && done) begin
      got = '{position, heading, stopped_here, task_active, task_station,
              target_flags, clockwise_flags, counter_flags};
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_status.pop_front();
        if (got.position !== want.position)
          $display("%0t: position exp %0d got %0d", $time, want.position, got.position);
        if (got.heading !== want.heading)
          $display("%0t: heading exp %0d got %0d", $time, want.heading, got.heading);
        if (got.stopped_here !== want.stopped_here)
          $display("%0t: stopped_here exp %0b got %0b", $time, want.stopped_here,
                   got.stopped_here);
        if (got.task_active !== want.task_active)
          $display("%0t: task_active exp %0b got %0b", $time, want.task_active,
                   got.task_active);
        if (got.task_station !== want.task_station)
          $display("%0t: task_station exp %0d got %0d", $time, want.task_station,
                   got.task_station);
        if (got.target_flags !== want.target_flags)
          $display("%0t: target_flags exp %h got %h", $time, want.target_flags,
                   got.target_flags);
        if (got.clockwise_flags !== want.clockwise_flags)
          $display("%0t: clockwise_flags exp %h got %h", $time, want.clockwise_flags,
                   got.clockwise_flags);
        if (got.counter_flags !== want.counter_flags)
          $display("%0t: counter_flags exp %h got %h", $time, want.counter_flags,
                   got.counter_flags);
        if (got !== want) errors++;
      end
    end
  end

  // start stays high between back-to-back items; it drops only while idling
  task automatic send_item(logic [1:0] kind, logic [4:0] stn);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    station <= stn;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_status.push_back(predict_status(kind, stn));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (220) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rssd_pkg::REG_COUNT) m_count = val;
    else m_spacing = val[2:0];
    clear_dispatch();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_item(rssd_pkg::REQ_TICK, 5'($urandom_range(31)));
  endtask

  task automatic test_directed();
    send_item(rssd_pkg::REQ_TARGET, 5'd0);
    send_item(rssd_pkg::REQ_CW, 5'd11);
    send_item(rssd_pkg::REQ_TARGET, 5'd1);
    send_item(rssd_pkg::REQ_TARGET, 5'd1);
    send_item(rssd_pkg::REQ_CW, 5'd10);
    send_item(rssd_pkg::REQ_CCW, 5'd6);
    send_item(rssd_pkg::REQ_CCW, 5'd31);
    run_ticks(14);
    wait_drained();
  endtask

  task automatic test_fill_store();
    write_reg(rssd_pkg::REG_COUNT, 5'd16);
    for (int s = 1; s <= 16; s++) begin
      send_item(rssd_pkg::REQ_TARGET, 5'(s));
      send_item(rssd_pkg::REQ_CW, 5'(s));
      send_item(rssd_pkg::REQ_CCW, 5'(s));
    end
    send_item(rssd_pkg::REQ_TICK, 5'd0);
    send_item(rssd_pkg::REQ_TARGET, 5'd16);
    run_ticks(40);
  endtask

  task automatic test_random(int n, int pct);
    logic [1:0] k;
    gap_pct = pct;
    for (int i = 0; i < n; i++) begin
      k = 2'($urandom_range(3));
      if ($urandom_range(9) < 5) k = rssd_pkg::REQ_TICK;
      send_item(k, ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                                              5'($urandom_range(1, 16)));
    end
  endtask

  task automatic test_settings();
    write_reg(rssd_pkg::REG_SPACING, 5'd7);
    test_random(50, 0);
    write_reg(rssd_pkg::REG_COUNT, 5'd2);
    write_reg(rssd_pkg::REG_SPACING, 5'd1);
    test_random(40, 0);
    write_reg(rssd_pkg::REG_COUNT, 5'd31);
    write_reg(rssd_pkg::REG_SPACING, 5'd0);
    test_random(40, 0);
    write_reg(rssd_pkg::REG_COUNT, 5'd0);
    write_reg(rssd_pkg::REG_SPACING, 5'd3);
    test_random(40, 0);
  endtask

  initial begin
    m_count = 5'd10;
    m_spacing = 3'd2;
    clear_dispatch();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_store();
    write_reg(rssd_pkg::REG_COUNT, 5'd12);
    write_reg(rssd_pkg::REG_SPACING, 5'd2);
    test_random(60, 24);
    test_random(60, 46);
    test_settings();
    gap_pct = 0;
    wait_drained();
    if (errors == 0) $display("ring_shuttle_sstf_dispatcher_unit regression: pass");
    else $display("ring_shuttle_sstf_dispatcher_unit regression: fail");
    $finish;
  end

endmodule
